/* design/tzg_pkg.sv */
// ---------------------------------------------------------------------------
// tzg_pkg: shared types and constants of the triangle rasterizer
// Frame geometry, arithmetic widths, operation codes and the item and status
// structs that pass between the front, the back and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tzg_pkg;

	// Frame and depth geometry.
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int DEPTH_BITS  = 16;
	localparam int X_BITS      = $clog2(MAX_WIDTH);
	localparam int Y_BITS      = $clog2(MAX_HEIGHT);
	localparam int ADDR_BITS   = X_BITS + Y_BITS;
	localparam int STORED_BITS = DEPTH_BITS + 1;
	localparam int GRAY_BITS   = 8;
	localparam int WORD_BITS   = STORED_BITS + GRAY_BITS;
	localparam int FRAME_BITS  = 9;
	localparam int COUNT_BITS  = 17;

	// Arithmetic widths.
	localparam int COORD_BITS = 11;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int DEN_BITS   = 23;
	localparam int WGT_BITS   = 28;
	localparam int NUM_BITS   = DEPTH_BITS + DEN_BITS + 1;
	localparam int QUO_BITS   = DEPTH_BITS;

	localparam logic [STORED_BITS-1:0] DEPTH_EMPTY = {STORED_BITS{1'b1}};

	// Input operation codes.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_VERTEX = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Result kinds.
	localparam logic RES_READ = 1'b0;
	localparam logic RES_TRI  = 1'b1;

	// One queued item.
	typedef struct packed {
		logic [1:0]                   kind;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [DEPTH_BITS-1:0]        z;
		logic [GRAY_BITS-1:0]         i;
	} item_t;

	// Active frame size after saturation.
	typedef struct packed {
		logic [FRAME_BITS-1:0] w;
		logic [FRAME_BITS-1:0] h;
	} frame_t;

	// Status of the back part seen by the front.
	typedef struct packed {
		logic booting;
	} back_status_t;

endpackage
`default_nettype wire

/* design/triangle_raster_zbuffer_gouraud.sv */
// ---------------------------------------------------------------------------
// triangle_raster_zbuffer_gouraud: triangle rasterizer with depth buffer
// Every third vertex closes a triangle that is drawn with interpolated depth
// and gray into a 256 x 256 pixel memory; clear and read operations included.
//
//   channel  direction  signals
//   in       input      in_valid/in_ready, opcode, coord_x, coord_y,
//                       vertex_depth, vertex_intensity
//   out      output     out_valid/out_ready, result_kind, pixel_gray,
//                       pixel_depth, pixels_written, degenerate
//   cfg      input      cfg_we, cfg_index, cfg_data
//
// A closing vertex sets up the triangle and then tests each bounding-box
// pixel; an inside pixel goes through the 16-step dividers and the depth test.
// A clear, and the sweep after reset, write all 65536 pixels, one pixel per cycle;
// no item is taken during the sweep after reset.
// The two-entry queue keeps taking items, until it is full, while the back part
// works or waits for a result to be taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module triangle_raster_zbuffer_gouraud (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	output logic                                    in_ready,
	input  wire [1:0]                               opcode,
	input  wire signed [tzg_pkg::COORD_BITS-1:0]    coord_x,
	input  wire signed [tzg_pkg::COORD_BITS-1:0]    coord_y,
	input  wire [tzg_pkg::DEPTH_BITS-1:0]           vertex_depth,
	input  wire [tzg_pkg::GRAY_BITS-1:0]            vertex_intensity,
	output logic                                    out_valid,
	input  wire                                     out_ready,
	output logic                                    result_kind,
	output logic [tzg_pkg::GRAY_BITS-1:0]           pixel_gray,
	output logic [tzg_pkg::STORED_BITS-1:0]         pixel_depth,
	output logic [tzg_pkg::COUNT_BITS-1:0]          pixels_written,
	output logic                                    degenerate,
	input  wire                                     cfg_we,
	input  wire                                     cfg_index,
	input  wire [tzg_pkg::FRAME_BITS-1:0]           cfg_data
);

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [tzg_pkg::FRAME_BITS-1:0] W_MAX = tzg_pkg::FRAME_BITS'(tzg_pkg::MAX_WIDTH);
	localparam logic [tzg_pkg::FRAME_BITS-1:0] H_MAX = tzg_pkg::FRAME_BITS'(tzg_pkg::MAX_HEIGHT);

	logic [tzg_pkg::FRAME_BITS-1:0] width_q;
	logic [tzg_pkg::FRAME_BITS-1:0] height_q;
	tzg_pkg::frame_t                frame;
	tzg_pkg::back_status_t          status;
	logic                           q_valid;
	tzg_pkg::item_t                 q_item;
	logic                           q_pop;

	// Frame size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_MAX;
			height_q <= H_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate the frame size to its legal range.
	always_comb begin
		frame.w = (width_q == '0) ? tzg_pkg::FRAME_BITS'(1) : (width_q > W_MAX) ? W_MAX : width_q;
		frame.h = (height_q == '0) ? tzg_pkg::FRAME_BITS'(1) :
			(height_q > H_MAX) ? H_MAX : height_q;
	end

	tzg_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.vertex_depth    (vertex_depth),
		.vertex_intensity(vertex_intensity),
		.status          (status),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	tzg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame         (frame),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.pixel_gray    (pixel_gray),
		.pixel_depth   (pixel_depth),
		.pixels_written(pixels_written),
		.degenerate    (degenerate)
	);

endmodule
`default_nettype wire

/* design/tzg_front.sv */
// ---------------------------------------------------------------------------
// tzg_front: input side of the rasterizer
// Accepts items, drops the unused opcode and queues the rest in a two-entry
// queue for the back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tzg_front (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      in_valid,
	output logic                                     in_ready,
	input  wire [1:0]                                opcode,
	input  wire signed [tzg_pkg::COORD_BITS-1:0]     coord_x,
	input  wire signed [tzg_pkg::COORD_BITS-1:0]     coord_y,
	input  wire [tzg_pkg::DEPTH_BITS-1:0]            vertex_depth,
	input  wire [tzg_pkg::GRAY_BITS-1:0]             vertex_intensity,
	input  tzg_pkg::back_status_t                    status,
	output logic                                     q_valid,
	output tzg_pkg::item_t                           q_item,
	input  wire                                      q_pop
);

	tzg_pkg::item_t q_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           known;
	logic           push;
	tzg_pkg::item_t new_item;

	// Classify the incoming item; the unused code is taken and dropped.
	always_comb begin
		known = (opcode == tzg_pkg::OP_CLEAR) || (opcode == tzg_pkg::OP_VERTEX) ||
			(opcode == tzg_pkg::OP_READ);
		new_item.kind = opcode;
		new_item.x    = coord_x;
		new_item.y    = coord_y;
		new_item.z    = vertex_depth;
		new_item.i    = vertex_intensity;
	end

	assign in_ready = (cnt_q != 2'd2) && !status.booting;
	assign push     = in_valid && in_ready && known;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = q_mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue fill count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> (cnt_q == 2'd2))
		else $error("full queue lost an item");
`endif

endmodule
`default_nettype wire

/* design/tzg_div.sv */
// ---------------------------------------------------------------------------
// tzg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; the numerator is known to
// be below the divisor times two to the quotient width.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tzg_div (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire [tzg_pkg::NUM_BITS-1:0]        num,
	input  wire [tzg_pkg::DEN_BITS-1:0]        den,
	output logic                               busy,
	output logic [tzg_pkg::QUO_BITS-1:0]       quo
);

	localparam int CNT_BITS = $clog2(tzg_pkg::QUO_BITS + 1);

	logic [tzg_pkg::NUM_BITS-1:0] rem_q;
	logic [tzg_pkg::NUM_BITS-1:0] dsh_q;
	logic [tzg_pkg::QUO_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]          cnt_q;
	logic                         fits;

	assign fits = (rem_q >= dsh_q);
	assign busy = (cnt_q != '0);
	assign quo  = quo_q;

	// One quotient bit per cycle, divisor shifted right each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			dsh_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			rem_q <= num;
			dsh_q <= tzg_pkg::NUM_BITS'(den) << (tzg_pkg::QUO_BITS - 1);
			quo_q <= '0;
			cnt_q <= CNT_BITS'(tzg_pkg::QUO_BITS);
		end else if (busy) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[tzg_pkg::QUO_BITS-2:0], fits};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* design/tzg_back.sv */
// ---------------------------------------------------------------------------
// tzg_back: execution side of the rasterizer
// Holds vertices, walks triangle bounding boxes, interpolates depth and gray,
// runs the depth test against the pixel memory, clears and reads it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tzg_back (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  tzg_pkg::frame_t                           frame,
	input  wire                                       q_valid,
	input  tzg_pkg::item_t                            q_item,
	output logic                                      q_pop,
	output tzg_pkg::back_status_t                     status,
	output logic                                      out_valid,
	input  wire                                       out_ready,
	output logic                                      result_kind,
	output logic [tzg_pkg::GRAY_BITS-1:0]             pixel_gray,
	output logic [tzg_pkg::STORED_BITS-1:0]           pixel_depth,
	output logic [tzg_pkg::COUNT_BITS-1:0]            pixels_written,
	output logic                                      degenerate
);

	localparam int DB = tzg_pkg::DIFF_BITS;
	localparam int PB = tzg_pkg::PROD_BITS;
	localparam int WB = tzg_pkg::WGT_BITS;
	localparam int XB = tzg_pkg::X_BITS;
	localparam int YB = tzg_pkg::Y_BITS;
	localparam int AB = tzg_pkg::ADDR_BITS;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_SU1  = 4'd3;
	localparam logic [3:0] S_SU2  = 4'd4;
	localparam logic [3:0] S_W1   = 4'd5;
	localparam logic [3:0] S_W2   = 4'd6;
	localparam logic [3:0] S_W3   = 4'd7;
	localparam logic [3:0] S_ACC  = 4'd8;
	localparam logic [3:0] S_DIV  = 4'd9;
	localparam logic [3:0] S_MRD  = 4'd10;
	localparam logic [3:0] S_MCMP = 4'd11;
	localparam logic [3:0] S_NEXT = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	// Pixel memory: depth above gray.
	logic [tzg_pkg::WORD_BITS-1:0] pix_mem [2**AB];
	logic [tzg_pkg::WORD_BITS-1:0] mem_rdata_q;
	logic                          mem_we;
	logic                          mem_re;
	logic [AB-1:0]                 mem_waddr;
	logic [AB-1:0]                 mem_raddr;
	logic [tzg_pkg::WORD_BITS-1:0] mem_wdata;

	logic [3:0]                            state_q;
	logic                                  boot_q;
	logic [AB-1:0]                         clr_cnt_q;
	logic [1:0]                            vcount_q;
	logic signed [tzg_pkg::COORD_BITS-1:0] vx_q [3];
	logic signed [tzg_pkg::COORD_BITS-1:0] vy_q [3];
	logic [tzg_pkg::DEPTH_BITS-1:0]        vz_q [3];
	logic [tzg_pkg::GRAY_BITS-1:0]         vi_q [3];
	logic signed [PB-1:0]                  pa_q;
	logic signed [PB-1:0]                  pb_q;
	logic signed [WB-1:0]                  w1_q;
	logic [tzg_pkg::DEN_BITS-1:0]          w_q [3];
	logic [tzg_pkg::DEN_BITS-1:0]          den_q;
	logic                                  neg_q;
	logic [XB-1:0]                         px_q;
	logic [YB-1:0]                         py_q;
	logic [XB-1:0]                         x0_q;
	logic [XB-1:0]                         x1_q;
	logic [YB-1:0]                         y0_q;
	logic [YB-1:0]                         y1_q;
	logic [1:0]                            k_q;
	logic [tzg_pkg::NUM_BITS-1:0]          accz_q;
	logic [tzg_pkg::NUM_BITS-1:0]          accg_q;
	logic [tzg_pkg::COUNT_BITS-1:0]        count_q;
	logic                                  degen_q;
	logic                                  rd_in_q;

	logic                                  out_valid_q;
	logic                                  out_kind_q;
	logic [tzg_pkg::GRAY_BITS-1:0]         out_gray_q;
	logic [tzg_pkg::STORED_BITS-1:0]       out_depth_q;
	logic [tzg_pkg::COUNT_BITS-1:0]        out_count_q;
	logic                                  out_degen_q;

	logic                                  div_start;
	logic                                  divz_busy;
	logic                                  divg_busy;
	logic [tzg_pkg::QUO_BITS-1:0]          div_z;
	logic [tzg_pkg::QUO_BITS-1:0]          div_g;

	// Combinational helpers.
	logic signed [DB-1:0]                  ax, ay, bx, by, cx, cy, pxs, pys;
	logic signed [PB:0]                    pdiff;
	logic signed [DB-1:0]                  minx, maxx, miny, maxy;
	logic signed [DB-1:0]                  x0c, x1c, y0c, y1c, xlim, ylim;
	logic signed [WB-1:0]                  w2c, w1n, w2n, w0c, dw;
	logic                                  in_tri;
	logic                                  rd_inframe;
	logic [tzg_pkg::DEPTH_BITS-1:0]        z_sel;
	logic [tzg_pkg::GRAY_BITS-1:0]         i_sel;
	logic [tzg_pkg::DEPTH_BITS+tzg_pkg::DEN_BITS-1:0] prod_z;
	logic [tzg_pkg::GRAY_BITS+tzg_pkg::DEN_BITS-1:0]  prod_g;
	logic                                  pass;

	function automatic logic signed [DB-1:0] sx(input logic signed [tzg_pkg::COORD_BITS-1:0] v);
		sx = DB'(v);
	endfunction

	function automatic logic signed [DB-1:0] min2(input logic signed [DB-1:0] a,
		input logic signed [DB-1:0] b);
		min2 = (a < b) ? a : b;
	endfunction

	function automatic logic signed [DB-1:0] max2(input logic signed [DB-1:0] a,
		input logic signed [DB-1:0] b);
		max2 = (a > b) ? a : b;
	endfunction

	// Vertex coordinates, pixel position and bounding box.
	always_comb begin
		ax   = sx(vx_q[0]);
		ay   = sx(vy_q[0]);
		bx   = sx(vx_q[1]);
		by   = sx(vy_q[1]);
		cx   = sx(vx_q[2]);
		cy   = sx(vy_q[2]);
		pxs  = signed'(DB'(px_q));
		pys  = signed'(DB'(py_q));
		pdiff = (PB+1)'(pa_q) - (PB+1)'(pb_q);
		minx = min2(min2(ax, bx), cx);
		maxx = max2(max2(ax, bx), cx);
		miny = min2(min2(ay, by), cy);
		maxy = max2(max2(ay, by), cy);
		xlim = signed'(DB'(frame.w)) - DB'(1);
		ylim = signed'(DB'(frame.h)) - DB'(1);
		x0c  = (minx < 0) ? '0 : minx;
		y0c  = (miny < 0) ? '0 : miny;
		x1c  = (maxx > xlim) ? xlim : maxx;
		y1c  = (maxy > ylim) ? ylim : maxy;
	end

	// Barycentric weights with the orientation folded in.
	always_comb begin
		w2c    = WB'(pdiff);
		w1n    = neg_q ? -w1_q : w1_q;
		w2n    = neg_q ? -w2c : w2c;
		dw     = signed'(WB'(den_q));
		w0c    = dw - w1n - w2n;
		in_tri = !w0c[WB-1] && !w1n[WB-1] && !w2n[WB-1];
	end

	// Vertex term of the interpolation sums.
	always_comb begin
		unique case (k_q)
			2'd0: begin
				z_sel = vz_q[0];
				i_sel = vi_q[0];
			end
			2'd1: begin
				z_sel = vz_q[1];
				i_sel = vi_q[1];
			end
			default: begin
				z_sel = vz_q[2];
				i_sel = vi_q[2];
			end
		endcase
		prod_z = z_sel * w_q[k_q];
		prod_g = i_sel * w_q[k_q];
	end

	assign rd_inframe = !q_item.x[tzg_pkg::COORD_BITS-1] && !q_item.y[tzg_pkg::COORD_BITS-1] &&
		(sx(q_item.x) < signed'(DB'(frame.w))) && (sx(q_item.y) < signed'(DB'(frame.h)));
	assign pass = ({1'b0, div_z} < mem_rdata_q[tzg_pkg::WORD_BITS-1:tzg_pkg::GRAY_BITS]);

	// Memory and queue control.
	always_comb begin
		q_pop     = (state_q == S_IDLE) && q_valid;
		mem_re    = (q_pop && q_item.kind == tzg_pkg::OP_READ) || (state_q == S_MRD);
		mem_raddr = (state_q == S_MRD) ? {py_q, px_q} :
			{q_item.y[YB-1:0], q_item.x[XB-1:0]};
		mem_we    = (state_q == S_CLR) || (state_q == S_MCMP && pass);
		mem_waddr = (state_q == S_CLR) ? clr_cnt_q : {py_q, px_q};
		mem_wdata = (state_q == S_CLR) ? {tzg_pkg::DEPTH_EMPTY, tzg_pkg::GRAY_BITS'(0)} :
			{1'b0, div_z, div_g[tzg_pkg::GRAY_BITS-1:0]};
		div_start = (state_q == S_ACC) && (k_q == 2'd2);
	end

	// Pixel memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pix_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= pix_mem[mem_raddr];
		end
	end

	tzg_div u_div_z (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (accz_q + tzg_pkg::NUM_BITS'(prod_z)),
		.den   (den_q),
		.busy  (divz_busy),
		.quo   (div_z)
	);

	tzg_div u_div_g (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (accg_q + tzg_pkg::NUM_BITS'(prod_g)),
		.den   (den_q),
		.busy  (divg_busy),
		.quo   (div_g)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			boot_q      <= 1'b1;
			clr_cnt_q   <= '0;
			vcount_q    <= 2'd0;
			out_valid_q <= 1'b0;
			k_q         <= 2'd0;
			count_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == {AB{1'b1}}) begin
						boot_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_item.kind)
							tzg_pkg::OP_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= S_CLR;
							end
							tzg_pkg::OP_READ: begin
								rd_in_q <= rd_inframe;
								state_q <= S_RD;
							end
							default: begin
								if (vcount_q == 2'd2) begin
									vcount_q <= 2'd0;
									state_q  <= S_SU1;
								end else begin
									vcount_q <= vcount_q + 2'd1;
								end
								vx_q[vcount_q] <= q_item.x;
								vy_q[vcount_q] <= q_item.y;
								vz_q[vcount_q] <= q_item.z;
								vi_q[vcount_q] <= q_item.i;
							end
						endcase
					end
				end
				S_RD: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= tzg_pkg::RES_READ;
						out_count_q <= '0;
						out_degen_q <= 1'b0;
						out_gray_q  <= rd_in_q ? mem_rdata_q[tzg_pkg::GRAY_BITS-1:0] : '0;
						out_depth_q <= rd_in_q ?
							mem_rdata_q[tzg_pkg::WORD_BITS-1:tzg_pkg::GRAY_BITS] :
							tzg_pkg::DEPTH_EMPTY;
						state_q     <= S_IDLE;
					end
				end
				S_SU1: begin
					pa_q    <= (cx - ax) * (by - ay);
					pb_q    <= (bx - ax) * (cy - ay);
					state_q <= S_SU2;
				end
				S_SU2: begin
					neg_q   <= pdiff[PB];
					den_q   <= pdiff[PB] ? tzg_pkg::DEN_BITS'(-pdiff) :
						tzg_pkg::DEN_BITS'(pdiff);
					count_q <= '0;
					degen_q <= (pdiff == '0);
					x0_q    <= x0c[XB-1:0];
					x1_q    <= x1c[XB-1:0];
					y0_q    <= y0c[YB-1:0];
					y1_q    <= y1c[YB-1:0];
					px_q    <= x0c[XB-1:0];
					py_q    <= y0c[YB-1:0];
					if (pdiff == '0 || x0c > x1c || y0c > y1c) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_W1;
					end
				end
				S_W1: begin
					pa_q    <= (ax - pxs) * (cy - ay);
					pb_q    <= (cx - ax) * (ay - pys);
					state_q <= S_W2;
				end
				S_W2: begin
					w1_q    <= WB'(pdiff);
					pa_q    <= (bx - ax) * (ay - pys);
					pb_q    <= (ax - pxs) * (by - ay);
					state_q <= S_W3;
				end
				S_W3: begin
					w_q[0] <= tzg_pkg::DEN_BITS'(w0c);
					w_q[1] <= tzg_pkg::DEN_BITS'(w1n);
					w_q[2] <= tzg_pkg::DEN_BITS'(w2n);
					accz_q <= '0;
					accg_q <= '0;
					k_q    <= 2'd0;
					state_q <= in_tri ? S_ACC : S_NEXT;
				end
				S_ACC: begin
					accz_q <= accz_q + tzg_pkg::NUM_BITS'(prod_z);
					accg_q <= accg_q + tzg_pkg::NUM_BITS'(prod_g);
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= S_DIV;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_DIV: begin
					if (!divz_busy && !divg_busy) begin
						state_q <= S_MRD;
					end
				end
				S_MRD: begin
					state_q <= S_MCMP;
				end
				S_MCMP: begin
					if (pass) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (py_q == y1_q) begin
						py_q <= y0_q;
						if (px_q == x1_q) begin
							state_q <= S_DONE;
						end else begin
							px_q    <= px_q + 1'b1;
							state_q <= S_W1;
						end
					end else begin
						py_q    <= py_q + 1'b1;
						state_q <= S_W1;
					end
				end
				S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= tzg_pkg::RES_TRI;
						out_gray_q  <= '0;
						out_depth_q <= '0;
						out_count_q <= count_q;
						out_degen_q <= degen_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status.booting = boot_q;
	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign pixel_gray     = out_gray_q;
	assign pixel_depth    = out_depth_q;
	assign pixels_written = out_count_q;
	assign degenerate     = out_degen_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_CLR) |-> !q_pop)
		else $error("item taken during a clearing sweep");
	assert property (@(posedge clk) disable iff (!arst_n) vcount_q != 2'd3)
		else $error("vertex count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RD || $past(state_q) == S_DONE))
		else $error("result raised outside a result state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == tzg_pkg::RES_TRI && out_degen_q) |-> (out_count_q == '0))
		else $error("degenerate triangle reported written pixels");
`endif

endmodule
`default_nettype wire
